>>> rtl/tlvd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the tag-length-value wire decoder.
// No dependencies; imported by every module of the block.
package tlvd_pkg;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIX64   = 3'd2,
    PH_FIX32   = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  localparam logic [1:0] REC_SCALAR  = 2'd0;
  localparam logic [1:0] REC_HEADER  = 2'd1;
  localparam logic [1:0] REC_PAYLOAD = 2'd2;
  localparam logic [1:0] REC_ERROR   = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_WIRE_KIND = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  localparam logic [2:0] WK_VARINT = 3'd0;
  localparam logic [2:0] WK_FIX64  = 3'd1;
  localparam logic [2:0] WK_LENGTH = 3'd2;
  localparam logic [2:0] WK_FIX32  = 3'd5;

  localparam logic [7:0] SEVEN_MASK  = 8'h7f;
  localparam logic [7:0] TAG_HI_MASK = 8'h70;
  localparam logic [2:0] WK_MASK     = 3'h7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] field;
    logic [2:0]  wire_kind;
    logic [63:0] value;
    logic        last;
    logic [1:0]  err;
  } record_t;

endpackage

>>> rtl/tlvd_core.sv
`timescale 1ns / 1ps
// Parse state and one-byte step logic of the wire decoder.
// Depends on tlvd_pkg for the phase type and the record layout.
module tlvd_core
  import tlvd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output logic       res_valid,
  output record_t    res
);

  phase_t                  phase, phase_next;
  logic [63:0]             acc, acc_next;
  logic [3:0]              byte_count, byte_count_next;
  logic [28:0]             cur_field, cur_field_next;
  logic [2:0]              cur_wk, cur_wk_next;
  logic [LENGTH_BITS-1:0]  remaining, remaining_next;
  logic                    error_seen, error_seen_next;

  logic [3:0]              bc;
  logic [2:0]              bcf;
  logic [5:0]              shamt7;
  logic [63:0]             acc_or7;
  logic [63:0]             acc_or8;
  logic                    more;
  logic                    do_fail;
  logic                    fail_in_tag;
  logic [1:0]              fail_code;
  logic [LENGTH_BITS-1:0]  rem_base;
  logic [LENGTH_BITS-1:0]  rem;

  assign more    = data_byte[7];
  assign bc      = (byte_count > 4'd9) ? 4'd9 : byte_count;
  assign bcf     = bc[3] ? 3'd7 : bc[2:0];
  assign shamt7  = 6'(7 * bc);
  assign acc_or7 = acc | ({56'd0, data_byte & SEVEN_MASK} << shamt7);
  assign acc_or8 = acc | ({56'd0, data_byte} << {bcf, 3'b000});
  assign rem_base = (remaining == '0) ? {{(LENGTH_BITS-1){1'b0}}, 1'b1} : remaining;
  assign rem      = rem_base - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    byte_count_next = byte_count;
    cur_field_next  = cur_field;
    cur_wk_next     = cur_wk;
    remaining_next  = remaining;
    error_seen_next = error_seen;
    res_valid       = 1'b0;
    res             = '0;
    do_fail         = 1'b0;
    fail_in_tag     = 1'b0;
    fail_code       = ERR_NONE;

    if (error_seen) begin
      if (end_of_buffer) begin
        error_seen_next = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_TAG: begin
          if (bc >= 4'd4 && (((data_byte & TAG_HI_MASK) != 8'd0) || more)) begin
            do_fail     = 1'b1;
            fail_in_tag = 1'b1;
            fail_code   = ERR_OVERFLOW;
          end else if (more) begin
            acc_next        = acc_or7;
            byte_count_next = bc + 4'd1;
            if (end_of_buffer) begin
              do_fail     = 1'b1;
              fail_in_tag = 1'b1;
              fail_code   = ERR_TRUNCATED;
            end
          end else begin
            cur_field_next  = acc_or7[31:3];
            cur_wk_next     = acc_or7[2:0] & WK_MASK;
            acc_next        = '0;
            byte_count_next = '0;
            if (cur_wk_next != WK_VARINT && cur_wk_next != WK_FIX64 &&
                cur_wk_next != WK_LENGTH && cur_wk_next != WK_FIX32) begin
              do_fail   = 1'b1;
              fail_code = ERR_WIRE_KIND;
            end else if (end_of_buffer) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end else begin
              case (cur_wk_next)
                WK_VARINT: phase_next = PH_VARINT;
                WK_FIX64:  phase_next = PH_FIX64;
                WK_LENGTH: phase_next = PH_LENGTH;
                default:   phase_next = PH_FIX32;
              endcase
            end
          end
        end
        PH_VARINT, PH_LENGTH: begin
          if (bc >= 4'd9 && more) begin
            do_fail   = 1'b1;
            fail_code = ERR_OVERFLOW;
          end else if (more) begin
            acc_next        = acc_or7;
            byte_count_next = bc + 4'd1;
            if (end_of_buffer) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end
          end else if (phase == PH_VARINT) begin
            res_valid       = 1'b1;
            res             = '{REC_SCALAR, cur_field, cur_wk, acc_or7, 1'b1, ERR_NONE};
            phase_next      = PH_TAG;
            acc_next        = '0;
            byte_count_next = '0;
          end else if (|(acc_or7 >> LENGTH_BITS)) begin
            do_fail   = 1'b1;
            fail_code = ERR_OVERFLOW;
          end else if (acc_or7 == 64'd0) begin
            res_valid       = 1'b1;
            res             = '{REC_HEADER, cur_field, cur_wk, 64'd0, 1'b1, ERR_NONE};
            phase_next      = PH_TAG;
            acc_next        = '0;
            byte_count_next = '0;
          end else if (end_of_buffer) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            res_valid       = 1'b1;
            res             = '{REC_HEADER, cur_field, cur_wk, acc_or7, 1'b0, ERR_NONE};
            remaining_next  = acc_or7[LENGTH_BITS-1:0];
            acc_next        = '0;
            byte_count_next = '0;
            phase_next      = PH_PAYLOAD;
          end
        end
        PH_FIX64, PH_FIX32: begin
          if ((phase == PH_FIX64) ? (bcf == 3'd7) : (bcf >= 3'd3)) begin
            res_valid       = 1'b1;
            res             = '{REC_SCALAR, cur_field, cur_wk, acc_or8, 1'b1, ERR_NONE};
            phase_next      = PH_TAG;
            acc_next        = '0;
            byte_count_next = '0;
          end else begin
            acc_next        = acc_or8;
            byte_count_next = {1'b0, bcf} + 4'd1;
            if (end_of_buffer) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end
          end
        end
        PH_PAYLOAD: begin
          if (end_of_buffer && rem != '0) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            remaining_next = rem;
            res_valid      = 1'b1;
            res            = '{REC_PAYLOAD, cur_field, cur_wk, {56'd0, data_byte},
                               (rem == '0), ERR_NONE};
            if (rem == '0) begin
              phase_next      = PH_TAG;
              acc_next        = '0;
              byte_count_next = '0;
            end
          end
        end
        default: begin
          phase_next      = PH_TAG;
          acc_next        = '0;
          byte_count_next = '0;
        end
      endcase

      if (do_fail) begin
        res_valid       = 1'b1;
        res             = '{REC_ERROR, fail_in_tag ? 29'd0 : cur_field_next,
                            fail_in_tag ? 3'd0 : cur_wk_next, 64'd0, 1'b1, fail_code};
        error_seen_next = !end_of_buffer;
        phase_next      = PH_TAG;
        acc_next        = '0;
        byte_count_next = '0;
        remaining_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      acc        <= '0;
      byte_count <= '0;
      cur_field  <= '0;
      cur_wk     <= '0;
      remaining  <= '0;
      error_seen <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      acc        <= acc_next;
      byte_count <= byte_count_next;
      cur_field  <= cur_field_next;
      cur_wk     <= cur_wk_next;
      remaining  <= remaining_next;
      error_seen <= error_seen_next;
    end
  end

endmodule

>>> rtl/tlvd_out_queue.sv
`timescale 1ns / 1ps
// Two-entry result register with skid slot for the wire decoder.
// Depends on tlvd_pkg for the record layout.
module tlvd_out_queue
  import tlvd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  record_t push_rec,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output record_t out_rec
);

  logic    v0, v1;
  record_t s0, s1;
  logic    pop;

  assign pop       = v0 && out_ready;
  assign room      = !v1;
  assign out_valid = v0;
  assign out_rec   = s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop && !push) begin
      if (v1) begin
        v1 <= 1'b0;
      end else begin
        v0 <= 1'b0;
      end
    end else if (!pop && push) begin
      if (v0) begin
        v1 <= 1'b1;
      end else begin
        v0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1) begin
        s0 <= s1;
        if (push) begin
          s1 <= push_rec;
        end
      end else if (push) begin
        s0 <= push_rec;
      end
    end else if (push) begin
      if (v0) begin
        s1 <= push_rec;
      end else begin
        s0 <= push_rec;
      end
    end
  end

endmodule

>>> rtl/tag_length_value_wire_decoder_unit.sv
`timescale 1ns / 1ps
// Decodes a protobuf-style wire stream, one byte per cycle, into scalar, length header,
// payload byte and error records. Each accepted byte is parsed in the cycle it is taken
// and its record, if any, is registered into the result queue. A two-entry result register lets
// input continue while one record waits; in_ready falls only when two records are held
// unread. Sustained rate is one byte per cycle while in_ready is high, as each byte's parse step is combinational.
// Depends on tlvd_pkg, tlvd_core and tlvd_out_queue.
module tag_length_value_wire_decoder_unit
  import tlvd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  record_kind,
  output logic [28:0] field_number,
  output logic [2:0]  wire_kind,
  output logic [63:0] field_value,
  output logic        last_of_field,
  output logic [1:0]  error_code
);

  logic    step;
  logic    res_valid;
  record_t res;
  record_t out_rec;

  assign step = in_valid && in_ready;

  tlvd_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .res_valid    (res_valid),
    .res          (res)
  );

  tlvd_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (step && res_valid),
    .push_rec (res),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rec  (out_rec)
  );

  assign record_kind   = out_rec.kind;
  assign field_number  = out_rec.field;
  assign wire_kind     = out_rec.wire_kind;
  assign field_value   = out_rec.value;
  assign last_of_field = out_rec.last;
  assign error_code    = out_rec.err;

endmodule

>>> rtl/tlvd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the wire decoder and the bind that attaches them.
// Depends on tlvd_pkg and tag_length_value_wire_decoder_unit.
module tlvd_checker
  import tlvd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  record_kind,
  input logic [63:0] field_value,
  input logic        last_of_field,
  input logic [1:0]  error_code
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(record_kind) &&
      $stable(field_value) && $stable(last_of_field) && $stable(error_code))
    else $error("result item changed while stalled");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == REC_ERROR |->
      last_of_field && field_value == 64'd0 && error_code != ERR_NONE)
    else $error("malformed error item");

  a_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind != REC_ERROR |-> error_code == ERR_NONE)
    else $error("error code on a data item");

  a_scalar: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == REC_SCALAR |-> last_of_field)
    else $error("scalar item not marked last");

endmodule

bind tag_length_value_wire_decoder_unit tlvd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .record_kind  (record_kind),
  .field_value  (field_value),
  .last_of_field(last_of_field),
  .error_code   (error_code)
);

>>> dv/tlvd_wire_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the wire decoder: predicts the record each accepted byte yields
// and compares it, field by field, with what leaves the output channel.
// Depends on tlvd_pkg; instantiated beside the block by the testbench top.
module tlvd_wire_checker
  import tlvd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  record_kind,
  input  logic [28:0] field_number,
  input  logic [2:0]  wire_kind,
  input  logic [63:0] field_value,
  input  logic        last_of_field,
  input  logic [1:0]  error_code,
  output int          failures,
  output int          pending,
  output int          bytes_decoded,
  output int          records_checked,
  output int          error_records
);

  localparam logic [63:0] LENGTH_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

  phase_t      phase;
  logic [63:0] acc;
  logic [3:0]  nbytes;
  logic [28:0] cur_field;
  logic [2:0]  cur_wk;
  logic [63:0] remaining;
  logic        skipping;
  record_t     expected_records[$];
  int          n_fail;
  int          n_bytes;
  int          n_checked;
  int          n_err;

  function automatic record_t make_record(logic [1:0] kind, logic [28:0] fnum,
                                          logic [2:0] wk, logic [63:0] val,
                                          logic last, logic [1:0] err);
    return {kind, fnum, wk, val, last, err};
  endfunction

  task automatic restart_tag();
    phase  = PH_TAG;
    acc    = '0;
    nbytes = '0;
  endtask

  task automatic raise_error(input logic [1:0] code, input logic eob, input logic in_tag,
                             output record_t rec);
    rec = make_record(REC_ERROR, in_tag ? 29'd0 : cur_field, in_tag ? 3'd0 : cur_wk,
                      64'd0, 1'b1, code);
    skipping  = !eob;
    remaining = '0;
    restart_tag();
  endtask

  task automatic decode_byte(input logic [7:0] d, input logic eob,
                             output logic has, output record_t rec);
    logic        more;
    logic [3:0]  bc;
    logic [2:0]  wk;
    logic [63:0] v;
    logic [63:0] rem;
    logic [3:0]  need;
    logic        is_last;
    more = d[7];
    has  = 1'b0;
    rec  = '0;
    bc   = (nbytes > 4'd9) ? 4'd9 : nbytes;
    n_bytes++;
    if (skipping) begin
      if (eob) skipping = 1'b0;
      return;
    end
    case (phase)
      PH_TAG: begin
        if (bc >= 4'd4 && ((d & TAG_HI_MASK) != 8'd0 || more)) begin
          raise_error(ERR_OVERFLOW, eob, 1'b1, rec);
          has = 1'b1;
          return;
        end
        acc |= {57'd0, d[6:0]} << (7 * bc);
        if (more) begin
          nbytes = bc + 4'd1;
          if (eob) begin
            raise_error(ERR_TRUNCATED, eob, 1'b1, rec);
            has = 1'b1;
          end
          return;
        end
        wk        = acc[2:0] & WK_MASK;
        cur_field = acc[31:3];
        cur_wk    = wk;
        acc       = '0;
        nbytes    = '0;
        if (wk != WK_VARINT && wk != WK_FIX64 && wk != WK_LENGTH && wk != WK_FIX32) begin
          raise_error(ERR_WIRE_KIND, eob, 1'b0, rec);
          has = 1'b1;
        end else if (eob) begin
          raise_error(ERR_TRUNCATED, eob, 1'b0, rec);
          has = 1'b1;
        end else begin
          case (wk)
            WK_VARINT: phase = PH_VARINT;
            WK_FIX64:  phase = PH_FIX64;
            WK_LENGTH: phase = PH_LENGTH;
            default:   phase = PH_FIX32;
          endcase
        end
      end
      PH_VARINT, PH_LENGTH: begin
        has = 1'b1;
        if (bc >= 4'd9 && more) begin
          raise_error(ERR_OVERFLOW, eob, 1'b0, rec);
          return;
        end
        acc |= {57'd0, d[6:0]} << (7 * bc);
        if (more) begin
          has    = 1'b0;
          nbytes = bc + 4'd1;
          if (eob) begin
            raise_error(ERR_TRUNCATED, eob, 1'b0, rec);
            has = 1'b1;
          end
          return;
        end
        v = acc;
        if (phase == PH_VARINT) begin
          rec = make_record(REC_SCALAR, cur_field, cur_wk, v, 1'b1, ERR_NONE);
          restart_tag();
        end else if ((v & ~LENGTH_MASK) != 64'd0) begin
          raise_error(ERR_OVERFLOW, eob, 1'b0, rec);
        end else if (v == 64'd0) begin
          rec = make_record(REC_HEADER, cur_field, cur_wk, 64'd0, 1'b1, ERR_NONE);
          restart_tag();
        end else if (eob) begin
          raise_error(ERR_TRUNCATED, eob, 1'b0, rec);
        end else begin
          rec       = make_record(REC_HEADER, cur_field, cur_wk, v, 1'b0, ERR_NONE);
          remaining = v & LENGTH_MASK;
          acc       = '0;
          nbytes    = '0;
          phase     = PH_PAYLOAD;
        end
      end
      PH_FIX64, PH_FIX32: begin
        need = (phase == PH_FIX64) ? 4'd8 : 4'd4;
        if (bc > 4'd7) bc = 4'd7;
        acc |= {56'd0, d} << (8 * bc);
        if (bc + 4'd1 >= need) begin
          rec = make_record(REC_SCALAR, cur_field, cur_wk, acc, 1'b1, ERR_NONE);
          has = 1'b1;
          restart_tag();
        end else begin
          nbytes = bc + 4'd1;
          if (eob) begin
            raise_error(ERR_TRUNCATED, eob, 1'b0, rec);
            has = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        has = 1'b1;
        rem = remaining & LENGTH_MASK;
        if (rem == 64'd0) rem = 64'd1;
        rem     = rem - 64'd1;
        is_last = (rem == 64'd0);
        if (eob && !is_last) begin
          raise_error(ERR_TRUNCATED, eob, 1'b0, rec);
        end else begin
          remaining = rem;
          rec = make_record(REC_PAYLOAD, cur_field, cur_wk, {56'd0, d}, is_last, ERR_NONE);
          if (is_last) restart_tag();
        end
      end
      default: restart_tag();
    endcase
  endtask

  always @(posedge clk) begin : monitor
    logic    has;
    record_t rec;
    record_t got;
    record_t want;
    if (rst) begin
      restart_tag();
      cur_field = '0;
      cur_wk    = '0;
      remaining = '0;
      skipping  = 1'b0;
      expected_records.delete();
      n_fail    = 0;
      n_bytes   = 0;
      n_checked = 0;
      n_err     = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(data_byte, end_of_buffer, has, rec);
        if (has) expected_records = {expected_records, rec};
      end
      if (out_valid && out_ready) begin
        got = {record_kind, field_number, wire_kind, field_value, last_of_field, error_code};
        n_checked++;
        if (got.kind == REC_ERROR) n_err++;
        if (expected_records.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected record kind=%0d field=%0d wk=%0d value=%h last=%0d err=%0d",
                     $time, got.kind, got.field, got.wire_kind, got.value, got.last, got.err);
        end else begin
          want = expected_records.pop_front();
          if (got.kind !== want.kind || got.field !== want.field ||
              got.wire_kind !== want.wire_kind || got.value !== want.value ||
              got.last !== want.last || got.err !== want.err) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: record mismatch", $time);
              $display("  exp kind=%0d field=%0d wk=%0d value=%h last=%0d err=%0d",
                       want.kind, want.field, want.wire_kind, want.value, want.last,
                       want.err);
              $display("  got kind=%0d field=%0d wk=%0d value=%h last=%0d err=%0d",
                       got.kind, got.field, got.wire_kind, got.value, got.last,
                       got.err);
            end
          end
        end
      end
    end
    failures        <= n_fail;
    pending         <= expected_records.size();
    bytes_decoded   <= n_bytes;
    records_checked <= n_checked;
    error_records   <= n_err;
  end

endmodule

>>> dv/tag_length_value_wire_decoder_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the wire decoder: drives byte buffers, directed then random,
// with random gaps and receiver stalls, and gives the verdict.
// Depends on tlvd_pkg, the decoder RTL and tlvd_wire_checker.
module tag_length_value_wire_decoder_unit_test;
  import tlvd_pkg::*;

  localparam int ITEMS = 1850;

  localparam logic [2:0] WK_GROUP_START = 3'd3;
  localparam logic [2:0] WK_GROUP_END   = 3'd4;
  localparam logic [2:0] WK_RESERVED_6  = 3'd6;
  localparam logic [2:0] WK_RESERVED_7  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  record_kind;
  logic [28:0] field_number;
  logic [2:0]  wire_kind;
  logic [63:0] field_value;
  logic        last_of_field;
  logic [1:0]  error_code;

  int failures;
  int pending;
  int bytes_decoded;
  int records_checked;
  int error_records;

  logic       tx_gappy = 1'b1;
  logic [8:0] wire_bytes[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tag_length_value_wire_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_kind   (record_kind),
    .field_number  (field_number),
    .wire_kind     (wire_kind),
    .field_value   (field_value),
    .last_of_field (last_of_field),
    .error_code    (error_code)
  );

  tlvd_wire_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .end_of_buffer   (end_of_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .record_kind     (record_kind),
    .field_number    (field_number),
    .wire_kind       (wire_kind),
    .field_value     (field_value),
    .last_of_field   (last_of_field),
    .error_code      (error_code),
    .failures        (failures),
    .pending         (pending),
    .bytes_decoded   (bytes_decoded),
    .records_checked (records_checked),
    .error_records   (error_records)
  );

  function automatic logic [63:0] random_varint_value();
    int          w;
    logic [63:0] v;
    w = $urandom_range(0, 64);
    v = {$urandom, $urandom};
    if (w < 64) v &= (64'd1 << w) - 64'd1;
    return v;
  endfunction

  task automatic add_byte(input logic [8:0] wb);
    wire_bytes = {wire_bytes, wb};
  endtask

  task automatic put_varint(input logic [63:0] v, input int len);
    int         n;
    int         i;
    logic [7:0] b;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 64'd0) n++;
    if (len < n) len = n;
    for (i = 0; i < len; i++) begin
      b = (i < 10) ? (8'(v >> (7 * i)) & SEVEN_MASK) : (8'($urandom) & SEVEN_MASK);
      if (i == 9) b |= 8'($urandom) & 8'h7e;
      if (i < len - 1) b |= 8'h80;
      add_byte({1'b0, b});
    end
  endtask

  task automatic put_tag(input logic [28:0] fnum, input logic [2:0] wk, input int len);
    logic [31:0] tag;
    int          n;
    int          i;
    logic [7:0]  b;
    tag = {fnum, wk};
    n = 1;
    while (n < 5 && (tag >> (7 * n)) != 32'd0) n++;
    if (len < n) len = n;
    if (len > 5) len = 5;
    for (i = 0; i < len; i++) begin
      b = 8'(tag >> (7 * i)) & SEVEN_MASK;
      if (i < len - 1) b |= 8'h80;
      add_byte({1'b0, b});
    end
  endtask

  task automatic send_buffer();
    int gap;
    foreach (wire_bytes[i]) begin
      gap = tx_gappy ? $urandom_range(0, 14) : 0;
      @(negedge clk);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid      <= 1'b1;
      data_byte     <= wire_bytes[i][7:0];
      end_of_buffer <= wire_bytes[i][8];
      do @(posedge clk); while (!in_ready);
    end
  endtask

  initial begin : stimulus
    int          pick;
    int          nfields;
    int          sel;
    int          pad;
    int          len;
    int          keep;
    int          f;
    int          k;
    logic [28:0] fnum;
    logic [63:0] v;
    logic [7:0]  b;
    logic [8:0]  tail;
    logic        stop;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // varint zero, fixed32 all ones, empty field, one-byte payload, bad kind,
    // tag cut on the last byte, tag too long, fixed64 cut short
    wire_bytes = '{9'h008, 9'h000, 9'h015, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,
                   9'h01a, 9'h000, 9'h022, 9'h001, 9'h1a5, 9'h10b, 9'h180,
                   9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h17f, 9'h009, 9'h011, 9'h122};
    send_buffer();

    while (bytes_decoded < ITEMS) begin
      wire_bytes.delete();
      tx_gappy = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++)
          add_byte({($urandom_range(0, 7) == 0), 8'($urandom)});
      end else begin
        nfields = $urandom_range(1, 5);
        stop = 1'b0;
        for (f = 0; f < nfields && !stop; f++) begin
          case ($urandom_range(0, 3))
            0:       fnum = 29'($urandom_range(1, 15));
            1:       fnum = 29'($urandom_range(16, 4095));
            2:       fnum = 29'($urandom);
            default: fnum = ($urandom_range(0, 1) != 0) ? 29'h1fffffff : 29'h0;
          endcase
          pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
          sel = (pick >= 85) ? $urandom_range(0, 11) : $urandom_range(0, 7);
          case (sel)
            0, 1: begin
              put_tag(fnum, WK_VARINT, pad);
              put_varint(random_varint_value(), pad);
            end
            2: begin
              put_tag(fnum, WK_FIX64, pad);
              for (k = 0; k < 8; k++) add_byte({1'b0, 8'($urandom)});
            end
            3: begin
              put_tag(fnum, WK_FIX32, pad);
              for (k = 0; k < 4; k++) add_byte({1'b0, 8'($urandom)});
            end
            4, 5, 6: begin
              len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
              put_tag(fnum, WK_LENGTH, pad);
              put_varint(64'(len), pad);
              for (k = 0; k < len; k++) add_byte({1'b0, 8'($urandom)});
            end
            7: begin
              case ($urandom_range(0, 4))
                0:       v = 64'd0;
                1:       v = {64{1'b1}};
                2:       v = 64'd1 << 63;
                3:       v = 64'd127;
                default: v = 64'd128;
              endcase
              put_tag(fnum, WK_VARINT, pad);
              put_varint(v, ($urandom_range(0, 1) != 0) ? 10 : 0);
            end
            8: begin
              case ($urandom_range(0, 3))
                0:       put_tag(fnum, WK_GROUP_START, pad);
                1:       put_tag(fnum, WK_GROUP_END, pad);
                2:       put_tag(fnum, WK_RESERVED_6, pad);
                default: put_tag(fnum, WK_RESERVED_7, pad);
              endcase
            end
            9: begin
              put_tag(fnum, ($urandom_range(0, 1) != 0) ? WK_VARINT : WK_LENGTH, pad);
              put_varint(random_varint_value(), $urandom_range(11, 13));
            end
            10: begin
              for (k = 0; k < 4; k++) add_byte({1'b0, 8'($urandom) | 8'h80});
              b = 8'($urandom);
              if ((b & 8'hf0) == 8'd0) b |= 8'h10 << $urandom_range(0, 3);
              add_byte({1'b0, b});
            end
            default: begin
              put_tag(fnum, WK_LENGTH, pad);
              if ($urandom_range(0, 1) != 0) begin
                put_varint(random_varint_value() | (64'd1 << $urandom_range(32, 63)), pad);
              end else begin
                put_varint(64'({$urandom} | 32'h10000), pad);
                len = $urandom_range(0, 3);
                for (k = 0; k < len; k++) add_byte({1'b0, 8'($urandom)});
                stop = 1'b1;
              end
            end
          endcase
        end
        if (pick >= 75 && pick < 85 && wire_bytes.size() > 1) begin
          keep = $urandom_range(1, wire_bytes.size() - 1);
          while (wire_bytes.size() > keep) void'(wire_bytes.pop_back());
        end
      end
      // mark the buffer's last byte
      tail = wire_bytes.pop_back();
      add_byte({1'b1, tail[7:0]});
      send_buffer();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("decoded %0d bytes into %0d records, %0d of them error records",
             bytes_decoded, records_checked, error_records);
    $display("scalar, header, payload and error paths driven under sender gaps and receiver stalls");
    if (failures == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    int   stall;
    int   taken;
    logic gappy;
    taken = 0;
    gappy = 1'b1;
    wait (rst == 1'b0);
    forever begin
      if (taken % 50 == 0) gappy = ($urandom_range(0, 2) != 0);
      stall = gappy ? $urandom_range(0, 14) : 0;
      // hold off long enough for the block to back up into its input
      if (taken == 40 || taken == 700) stall = 200;
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : watchdog
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
